[rtl/prnb_pkg.sv]
package prnb_pkg;

  // Register indexes of the configuration port
  localparam logic [2:0] CFG_WEIGHT_CUBIC   = 3'd0;
  localparam logic [2:0] CFG_WEIGHT_SQUARE  = 3'd1;
  localparam logic [2:0] CFG_WEIGHT_LINEAR  = 3'd2;
  localparam logic [2:0] CFG_EPSILON        = 3'd3;
  localparam logic [2:0] CFG_INVERSE_LENGTH = 3'd4;

  // Input opcodes
  localparam logic OPC_ACCUM = 1'b0;
  localparam logic OPC_GRAD  = 1'b1;

  localparam int SH_W = 6;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] x_value;
    logic signed [15:0] grad_in;
    logic               end_of_row;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_w_cubic;
    logic signed [31:0] grad_w_square;
    logic signed [31:0] grad_w_linear;
    logic signed [31:0] grad_bias;
    logic               last;
  } out_item_t;

  // Operand sources of the shared multiplier
  typedef enum logic [4:0] {
    SRC_ONE, SRC_X, SRC_G, SRC_X2, SRC_X3, SRC_X2X, SRC_X3X2, SRC_PW, SRC_MX, SRC_N,
    SRC_Y, SRC_C, SRC_CC, SRC_V, SRC_T0, SRC_T1, SRC_W, SRC_GAM, SRC_ALP, SRC_D,
    SRC_INV, SRC_ACC, SRC_SG
  } src_t;

  // Writeback targets of a multiplier result
  typedef enum logic [4:0] {
    DST_X2, DST_X2S, DST_X3, DST_S4, DST_S6, DST_SXG, DST_SX2G, DST_SX3G, DST_V,
    DST_CC, DST_YCMP, DST_T0, DST_T1, DST_GAM, DST_ALP, DST_D, DST_ACC_SET,
    DST_ACC_ADD, DST_GX, DST_DW, DST_DB
  } dst_t;

  typedef struct packed {
    src_t            a_sel;
    src_t            b_sel;
    logic [SH_W-1:0] sh;
    dst_t            dst;
    logic [1:0]      idx;
    logic            last;
  } uop_t;

  typedef struct packed {
    logic       load;
    logic       clr_on_load;
    logic       add_grad;
    logic       start;
    uop_t       uop;
    logic [4:0] bit_idx;
    logic       out_load;
    logic       last;
    logic       clr_sums;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_sts_t;

  typedef struct packed {
    logic            start;
    logic [63:0]     a_mag;
    logic [63:0]     b_mag;
    logic            neg;
    logic [SH_W-1:0] sh;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
    logic [63:0]  res;
  } mul_rsp_t;

endpackage

[rtl/prnb_mul.sv]
module prnb_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  prnb_pkg::mul_req_t req,
  output prnb_pkg::mul_rsp_t rsp
);
  import prnb_pkg::*;

  logic                busy_r;
  logic [2:0]          cnt_r;
  logic                done_r;
  logic [63:0]         a_r, b_r;
  logic                neg_r;
  logic [SH_W-1:0]     sh_r;
  logic [63:0]         pp_r;
  logic [1:0]          ppsh_r;
  logic [127:0]        acc_r, rnd_r;
  logic [63:0]         res_r;

  logic [31:0]  a_part, b_part;
  logic [63:0]  pp_nxt;
  logic [127:0] pp_ext, half, q;
  logic [63:0]  lim, mag, res_nxt;
  logic         over;

  // Pick one 32x32 partial product per cycle, round, shift and saturate
  always_comb begin
    a_part = cnt_r[0] ? a_r[63:32] : a_r[31:0];
    b_part = cnt_r[1] ? b_r[63:32] : b_r[31:0];
    pp_nxt = a_part * b_part;
    case (ppsh_r)
      2'd0:    pp_ext = {64'd0, pp_r};
      2'd1:    pp_ext = {32'd0, pp_r, 32'd0};
      default: pp_ext = {pp_r, 64'd0};
    endcase
    half    = (sh_r == '0) ? 128'd0 : (128'd1 << (sh_r - 6'd1));
    q       = rnd_r >> sh_r;
    lim     = neg_r ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    over    = (|q[127:64]) || (q[63:0] > lim);
    mag     = over ? lim : q[63:0];
    res_nxt = neg_r ? (~mag + 64'd1) : mag;
  end

  // Sequence the operation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd6) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands, partial sums and result
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a_mag;
      b_r   <= req.b_mag;
      neg_r <= req.neg;
      sh_r  <= req.sh;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r <= 3'd3) begin
        pp_r   <= pp_nxt;
        ppsh_r <= {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
      end
      if (cnt_r >= 3'd1 && cnt_r <= 3'd4) begin
        acc_r <= acc_r + pp_ext;
      end
      if (cnt_r == 3'd5) begin
        rnd_r <= acc_r + half;
      end
      if (cnt_r == 3'd6) begin
        res_r <= res_nxt;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;
  assign rsp.res  = res_r;

endmodule

[rtl/prnb_dp.sv]
module prnb_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  prnb_pkg::in_item_t  in_data,
  input  prnb_pkg::dp_cmd_t   cmd,
  output prnb_pkg::dp_sts_t   sts,
  output prnb_pkg::out_item_t out_data
);
  import prnb_pkg::*;

  // Configuration
  logic signed [15:0] w_r [3];
  logic [31:0]        eps_r;
  logic [16:0]        invlen_r;

  // Item and scratch registers
  logic signed [15:0] x_r, g_r;
  logic [30:0]        x2_r;
  logic signed [45:0] x3_r;
  logic signed [63:0] s2_r, s4_r, s6_r, sxg_r, sx2g_r, sx3g_r, sg_r;
  logic [31:0]        y_r;
  logic [63:0]        cc_r, v_r;
  logic signed [63:0] t0_r, t1_r, acc_r;
  logic signed [31:0] gam_r [3];
  logic signed [31:0] alp_r [3];
  logic [31:0]        inv_r [3];
  logic signed [63:0] d_r [3];
  logic signed [31:0] gx_r, db_r;
  logic signed [31:0] dw_r [3];
  uop_t               uop_r;
  out_item_t          out_r;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  logic signed [64:0] a_val, b_val;
  logic signed [63:0] res, g24;
  logic [16:0]        n_val;
  logic               le72;

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      sat_add = s[63:0];
    end
  endfunction

  function automatic logic signed [63:0] sat_sub(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      sat_sub = s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      sat_sub = s[63:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // Select one operand value by source and branch index
  function automatic logic signed [64:0] pick(src_t s, logic [1:0] k);
    logic signed [63:0] pw, mx;
    case (k)
      2'd0:    begin pw = s2_r; mx = sxg_r;  end
      2'd1:    begin pw = s4_r; mx = sx2g_r; end
      default: begin pw = s6_r; mx = sx3g_r; end
    endcase
    case (s)
      SRC_ONE:  pick = 65'sd1;
      SRC_X:    pick = 65'(x_r);
      SRC_G:    pick = 65'(g_r);
      SRC_X2:   pick = {34'd0, x2_r};
      SRC_X3:   pick = 65'(x3_r);
      SRC_X2X:  pick = {{48{x_r[15]}}, x_r, 1'b0};
      SRC_X3X2: pick = {34'd0, x2_r} + {33'd0, x2_r, 1'b0};
      SRC_PW:   pick = pw[63] ? 65'sd0 : 65'(pw);
      SRC_MX:   pick = 65'(mx);
      SRC_N:    pick = {48'd0, n_val};
      SRC_Y:    pick = {33'd0, y_r};
      SRC_C:    pick = {33'd0, y_r | (32'd1 << cmd.bit_idx)};
      SRC_CC:   pick = {1'b0, cc_r};
      SRC_V:    pick = {1'b0, v_r};
      SRC_T0:   pick = 65'(t0_r);
      SRC_T1:   pick = 65'(t1_r);
      SRC_W:    pick = (k == 2'd0) ? 65'(w_r[2]) : (k == 2'd1) ? 65'(w_r[1]) : 65'(w_r[0]);
      SRC_GAM:  pick = (k == 2'd0) ? 65'(gam_r[0]) : (k == 2'd1) ? 65'(gam_r[1]) : 65'(gam_r[2]);
      SRC_ALP:  pick = (k == 2'd0) ? 65'(alp_r[0]) : (k == 2'd1) ? 65'(alp_r[1]) : 65'(alp_r[2]);
      SRC_D:    pick = (k == 2'd0) ? 65'(d_r[0]) : (k == 2'd1) ? 65'(d_r[1]) : 65'(d_r[2]);
      SRC_INV:  pick = (k == 2'd0) ? {33'd0, inv_r[0]} :
                       (k == 2'd1) ? {33'd0, inv_r[1]} : {33'd0, inv_r[2]};
      SRC_ACC:  pick = 65'(acc_r);
      SRC_SG:   pick = 65'(sg_r);
      default:  pick = 65'sd0;
    endcase
  endfunction

  // Form the multiplier request from the issued operation
  always_comb begin
    n_val      = (invlen_r > 17'd65536) ? 17'd65536 : invlen_r;
    a_val      = pick(cmd.uop.a_sel, cmd.uop.idx);
    b_val      = pick(cmd.uop.b_sel, cmd.uop.idx);
    mreq.start = cmd.start;
    mreq.a_mag = a_val[64] ? 64'(-a_val) : a_val[63:0];
    mreq.b_mag = b_val[64] ? 64'(-b_val) : b_val[63:0];
    mreq.neg   = a_val[64] ^ b_val[64];
    mreq.sh    = cmd.uop.sh;
    res        = mrsp.res;
    g24        = {{36{g_r[15]}}, g_r, 12'd0};
    le72       = (mrsp.prod[127:73] == '0) && (!mrsp.prod[72] || (mrsp.prod[71:0] == '0));
  end

  prnb_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .rsp  (mrsp)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r[0]   <= 16'sd4096;
      w_r[1]   <= 16'sd4096;
      w_r[2]   <= 16'sd4096;
      eps_r    <= 32'd4295;
      invlen_r <= 17'd65536;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WEIGHT_CUBIC:   w_r[0]   <= cfg_data[15:0];
        CFG_WEIGHT_SQUARE:  w_r[1]   <= cfg_data[15:0];
        CFG_WEIGHT_LINEAR:  w_r[2]   <= cfg_data[15:0];
        CFG_EPSILON:        eps_r    <= cfg_data;
        CFG_INVERSE_LENGTH: invlen_r <= cfg_data[16:0];
        default:            ;
      endcase
    end
  end

  // Row sums: load-time update, writeback accumulation, clear at row end
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_sums) begin
      s2_r   <= '0;
      s4_r   <= '0;
      s6_r   <= '0;
      sxg_r  <= '0;
      sx2g_r <= '0;
      sx3g_r <= '0;
      sg_r   <= '0;
    end else if (cmd.load) begin
      if (cmd.clr_on_load) begin
        s2_r   <= '0;
        s4_r   <= '0;
        s6_r   <= '0;
        sxg_r  <= '0;
        sx2g_r <= '0;
        sx3g_r <= '0;
      end
      if (cmd.add_grad) begin
        sg_r <= sat_add(cmd.clr_on_load ? 64'sd0 : sg_r,
                        {{36{in_data.grad_in[15]}}, in_data.grad_in, 12'd0});
      end
    end else if (mrsp.done) begin
      case (uop_r.dst)
        DST_X2S:  s2_r   <= sat_add(s2_r, res);
        DST_S4:   s4_r   <= sat_add(s4_r, res);
        DST_S6:   s6_r   <= sat_add(s6_r, res);
        DST_SXG:  sxg_r  <= sat_add(sxg_r, res);
        DST_SX2G: sx2g_r <= sat_add(sx2g_r, res);
        DST_SX3G: sx3g_r <= sat_add(sx3g_r, res);
        default:  ;
      endcase
    end
  end

  // Item capture and scratch writeback
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= in_data.x_value;
      g_r <= in_data.grad_in;
    end
    if (cmd.start) begin
      uop_r <= cmd.uop;
    end
    if (mrsp.done) begin
      case (uop_r.dst)
        DST_X2, DST_X2S: x2_r <= res[30:0];
        DST_X3:          x3_r <= res[45:0];
        DST_V: begin
          v_r <= res + {32'd0, eps_r};
          y_r <= '0;
        end
        DST_CC:          cc_r <= mrsp.prod[63:0];
        DST_YCMP: begin
          if (le72) begin
            y_r <= y_r | (32'd1 << cmd.bit_idx);
          end
        end
        DST_T0:          t0_r <= res;
        DST_T1:          t1_r <= res;
        DST_GAM:         gam_r[uop_r.idx] <= sat32(res);
        DST_ALP: begin
          alp_r[uop_r.idx] <= sat32(res);
          inv_r[uop_r.idx] <= y_r;
        end
        DST_D:           d_r[uop_r.idx] <= sat_sub(g24, res);
        DST_ACC_SET:     acc_r <= res;
        DST_ACC_ADD:     acc_r <= sat_add(acc_r, res);
        DST_GX:          gx_r <= sat32(res);
        DST_DW:          dw_r[uop_r.idx] <= sat32(res);
        DST_DB:          db_r <= sat32(res);
        default:         ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.grad_x <= gx_r;
      out_r.last   <= cmd.last;
      if (cmd.last) begin
        out_r.grad_w_cubic  <= dw_r[2];
        out_r.grad_w_square <= dw_r[1];
        out_r.grad_w_linear <= dw_r[0];
        out_r.grad_bias     <= db_r;
      end else begin
        out_r.grad_w_cubic  <= '0;
        out_r.grad_w_square <= '0;
        out_r.grad_w_linear <= '0;
        out_r.grad_bias     <= '0;
      end
    end
  end

  assign sts.done = mrsp.done;
  assign out_data = out_r;

endmodule

[rtl/prnb_ctrl.sv]
module prnb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  prnb_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output prnb_pkg::dp_cmd_t  cmd,
  input  prnb_pkg::dp_sts_t  sts
);
  import prnb_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE} state_t;
  typedef enum logic [2:0] {PH_ACC, PH_SCA, PH_ISQ, PH_SCB, PH_ELEM, PH_FIN} phase_t;

  state_t     state_r;
  phase_t     phase_r;
  logic [3:0] step_r;
  logic [1:0] k_r;
  logic [4:0] bit_r;
  logic       sub_r;
  logic       eor_r;
  logic       ready_r;
  logic       out_valid_r;

  uop_t       uop;
  logic       accept, out_free;

  function automatic uop_t mk(src_t a, src_t b, logic [SH_W-1:0] sh, dst_t d,
                              logic [1:0] idx, logic last);
    uop_t u;
    u.a_sel = a;
    u.b_sel = b;
    u.sh    = sh;
    u.dst   = d;
    u.idx   = idx;
    u.last  = last;
    return u;
  endfunction

  // Micro-program: one multiply per step
  function automatic uop_t prog(phase_t ph, logic [3:0] st, logic sb);
    uop_t u;
    u = mk(SRC_ACC, SRC_ONE, 6'd8, DST_GX, 2'd0, 1'b1);
    case (ph)
      PH_ACC: begin
        case (st)
          4'd0:    u = mk(SRC_X,  SRC_X,  6'd0,  DST_X2S,  2'd0, 1'b0);
          4'd1:    u = mk(SRC_X2, SRC_X,  6'd0,  DST_X3,   2'd0, 1'b0);
          4'd2:    u = mk(SRC_X2, SRC_X2, 6'd24, DST_S4,   2'd0, 1'b0);
          4'd3:    u = mk(SRC_X3, SRC_X3, 6'd48, DST_S6,   2'd0, 1'b0);
          4'd4:    u = mk(SRC_X,  SRC_G,  6'd0,  DST_SXG,  2'd0, 1'b0);
          4'd5:    u = mk(SRC_X2, SRC_G,  6'd12, DST_SX2G, 2'd0, 1'b0);
          default: u = mk(SRC_X3, SRC_G,  6'd24, DST_SX3G, 2'd0, 1'b1);
        endcase
      end
      PH_SCA: u = mk(SRC_PW, SRC_N, 6'd8, DST_V, 2'd0, 1'b1);
      PH_ISQ: begin
        if (!sb) begin
          u = mk(SRC_C, SRC_C, 6'd0, DST_CC, 2'd0, 1'b0);
        end else begin
          u = mk(SRC_CC, SRC_V, 6'd0, DST_YCMP, 2'd0, 1'b0);
        end
      end
      PH_SCB: begin
        case (st)
          4'd0:    u = mk(SRC_Y,  SRC_Y,  6'd8,  DST_T0,  2'd0, 1'b0);
          4'd1:    u = mk(SRC_MX, SRC_N,  6'd16, DST_T1,  2'd0, 1'b0);
          4'd2:    u = mk(SRC_T0, SRC_T1, 6'd40, DST_GAM, 2'd0, 1'b0);
          default: u = mk(SRC_W,  SRC_Y,  6'd16, DST_ALP, 2'd0, 1'b1);
        endcase
      end
      PH_ELEM: begin
        case (st)
          4'd0:    u = mk(SRC_X,   SRC_X,    6'd0,  DST_X2,      2'd0, 1'b0);
          4'd1:    u = mk(SRC_X2,  SRC_X,    6'd0,  DST_X3,      2'd0, 1'b0);
          4'd2:    u = mk(SRC_GAM, SRC_X,    6'd4,  DST_D,       2'd0, 1'b0);
          4'd3:    u = mk(SRC_GAM, SRC_X2,   6'd16, DST_D,       2'd1, 1'b0);
          4'd4:    u = mk(SRC_GAM, SRC_X3,   6'd28, DST_D,       2'd2, 1'b0);
          4'd5:    u = mk(SRC_ALP, SRC_D,    6'd16, DST_ACC_SET, 2'd0, 1'b0);
          4'd6:    u = mk(SRC_ALP, SRC_D,    6'd16, DST_T0,      2'd1, 1'b0);
          4'd7:    u = mk(SRC_T0,  SRC_X2X,  6'd12, DST_ACC_ADD, 2'd0, 1'b0);
          4'd8:    u = mk(SRC_ALP, SRC_D,    6'd16, DST_T0,      2'd2, 1'b0);
          4'd9:    u = mk(SRC_T0,  SRC_X3X2, 6'd24, DST_ACC_ADD, 2'd0, 1'b0);
          default: u = mk(SRC_ACC, SRC_ONE,  6'd8,  DST_GX,      2'd0, 1'b1);
        endcase
      end
      PH_FIN: begin
        case (st)
          4'd0:    u = mk(SRC_MX, SRC_INV, 6'd28, DST_DW, 2'd2, 1'b0);
          4'd1:    u = mk(SRC_MX, SRC_INV, 6'd28, DST_DW, 2'd1, 1'b0);
          4'd2:    u = mk(SRC_MX, SRC_INV, 6'd28, DST_DW, 2'd0, 1'b0);
          default: u = mk(SRC_SG, SRC_ONE, 6'd8,  DST_DB, 2'd0, 1'b1);
        endcase
      end
      default: ;
    endcase
    return u;
  endfunction

  // Decode the current step and drive the datapath
  always_comb begin
    uop = prog(phase_r, step_r, sub_r);
    if (phase_r == PH_SCA || phase_r == PH_SCB) begin
      uop.idx = k_r;
    end
    in_ready         = (state_r == ST_IDLE);
    accept           = in_valid && in_ready;
    out_free         = !out_valid_r || out_ready;
    cmd.load         = accept;
    cmd.clr_on_load  = accept && (in_data.opcode == OPC_ACCUM) && ready_r;
    cmd.add_grad     = accept && (in_data.opcode == OPC_ACCUM);
    cmd.start        = (state_r == ST_ISSUE);
    cmd.uop          = uop;
    cmd.bit_idx      = bit_r;
    cmd.out_load     = (state_r == ST_DONE) && out_free;
    cmd.last         = eor_r;
    cmd.clr_sums     = cmd.out_load && eor_r;
  end

  // Sequence items through the micro-program
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_ACC;
      step_r      <= '0;
      k_r         <= '0;
      bit_r       <= '0;
      sub_r       <= 1'b0;
      eor_r       <= 1'b0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            eor_r   <= in_data.end_of_row;
            step_r  <= '0;
            k_r     <= '0;
            state_r <= ST_ISSUE;
            if (in_data.opcode == OPC_ACCUM) begin
              ready_r <= 1'b0;
              phase_r <= PH_ACC;
            end else begin
              phase_r <= ready_r ? PH_ELEM : PH_SCA;
            end
          end
        end
        ST_ISSUE: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (sts.done) begin
            state_r <= ST_ISSUE;
            step_r  <= step_r + 4'd1;
            case (phase_r)
              PH_ACC: begin
                if (uop.last) begin
                  state_r <= ST_IDLE;
                end
              end
              PH_SCA: begin
                phase_r <= PH_ISQ;
                bit_r   <= 5'd31;
                sub_r   <= 1'b0;
              end
              PH_ISQ: begin
                if (!sub_r) begin
                  sub_r <= 1'b1;
                end else if (bit_r == 5'd0) begin
                  phase_r <= PH_SCB;
                  step_r  <= '0;
                end else begin
                  bit_r <= bit_r - 5'd1;
                  sub_r <= 1'b0;
                end
              end
              PH_SCB: begin
                if (uop.last) begin
                  step_r <= '0;
                  if (k_r == 2'd2) begin
                    ready_r <= 1'b1;
                    phase_r <= PH_ELEM;
                  end else begin
                    k_r     <= k_r + 2'd1;
                    phase_r <= PH_SCA;
                  end
                end
              end
              PH_ELEM: begin
                if (uop.last) begin
                  step_r <= '0;
                  if (eor_r) begin
                    phase_r <= PH_FIN;
                  end else begin
                    state_r <= ST_DONE;
                  end
                end
              end
              PH_FIN: begin
                if (uop.last) begin
                  state_r <= ST_DONE;
                end
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
            if (eor_r) begin
              ready_r <= 1'b0;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> (state_r == ST_WAIT))
    else $error("multiplier result outside wait state");

  a_elem_needs_scalars: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && (phase_r == PH_ELEM || phase_r == PH_FIN)) |-> ready_r)
    else $error("gradient step without row scalars");

  a_ready_from_scalars: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ready_r) |-> $past(phase_r == PH_SCB))
    else $error("row scalars marked ready outside scalar pass");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  a_bit_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT && !sts.done) |=> $stable(bit_r))
    else $error("square root bit moved during operation");
`endif

endmodule

[rtl/polynomial_rms_norm_backward_top.sv]
// Backward pass of a three-branch polynomial RMS norm, one row at a time. Send the row once
// with opcode 0 (accumulate) and then again with opcode 1 (gradient); each gradient
// transaction returns grad_x, and the one marked end_of_row also returns the row partials
// dw and db with last set. Accumulate transactions return nothing. All products run on one
// shared 32x32 multiplier that builds a 64x64 product from four partial products and then
// rounds and saturates. An accumulate transaction runs 7 multiplies, a gradient
// transaction 11 multiplies plus four more for end_of_row. The first gradient transaction
// of a row also forms the row scalars: per branch one mean, a 32-step bitwise inverse square
// root of two multiplies per step and four more multiplies. Input is taken only while no
// transaction is in progress; a finished result waits in the output register while the
// next transaction runs. Configure only while idle.
module polynomial_rms_norm_backward_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  prnb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output prnb_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import prnb_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  prnb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  prnb_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

[bench/polynomial_rms_norm_backward_top_tb.sv]
module polynomial_rms_norm_backward_top_tb;
  import prnb_pkg::*;

  localparam int LONG_ROW    = 60;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // Predictor state: registers, running sums and row scalars
  logic signed [15:0] weight_q [3];
  logic [31:0]        eps_q;
  logic [16:0]        inv_len_q;
  longint             acc_x2, acc_x4, acc_x6, acc_xg, acc_x2g, acc_x3g, acc_g;
  logic [31:0]        inv_rms_q [3];
  int                 gamma_q [3];
  int                 alpha_q [3];
  bit                 scalars_set;

  out_item_t expected_grads [$];
  int        mismatches;
  int        items_sent;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_request;
  int        hold_left;
  int        quiet_cycles;

  polynomial_rms_norm_backward_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------- arithmetic

  // round(a*b / 2^sh) half away from zero, saturated to 64 bits
  function automatic longint round_mul(longint a, longint b, int sh);
    logic         neg;
    logic [63:0]  ua, ub, lim;
    logic [128:0] p;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    p = 129'(ua) * 129'(ub);
    p = (p + (129'(1) << (sh - 1))) >> sh;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    if (p > 129'(lim)) p = 129'(lim);
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return longint'(s);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // largest y with y*y*v <= 2^72
  function automatic logic [31:0] inv_sqrt(logic [63:0] v);
    logic [31:0]  y, c;
    logic [127:0] p;
    y = '0;
    for (int b = 31; b >= 0; b--) begin
      c = y | (32'd1 << b);
      p = 128'(64'(c) * 64'(c)) * 128'(v);
      if (p <= (128'd1 << 72)) y = c;
    end
    return y;
  endfunction

  // --------------------------------------------------------------- predictor

  task automatic clear_row_sums();
    acc_x2 = 0; acc_x4 = 0; acc_x6 = 0;
    acc_xg = 0; acc_x2g = 0; acc_x3g = 0; acc_g = 0;
    scalars_set = 1'b0;
  endtask

  task automatic form_row_scalars();
    longint pw [3];
    longint mx [3];
    longint n, p, mean, i2, m;
    logic [63:0] v;
    pw = '{acc_x2, acc_x4, acc_x6};
    mx = '{acc_xg, acc_x2g, acc_x3g};
    n = (inv_len_q > 17'd65536) ? 65536 : longint'(inv_len_q);
    for (int k = 0; k < 3; k++) begin
      p = (pw[k] < 0) ? 0 : pw[k];
      mean = round_mul(p, n, 8);
      v = 64'(mean) + 64'(eps_q);
      inv_rms_q[k] = inv_sqrt(v);
      i2 = round_mul(longint'(inv_rms_q[k]), longint'(inv_rms_q[k]), 8);
      m = round_mul(mx[k], n, 16);
      gamma_q[k] = int'(clamp32(round_mul(i2, m, 40)));
      // branch k uses w of register 2 - k (linear, square, cubic)
      alpha_q[k] = int'(clamp32(round_mul(longint'(weight_q[2 - k]),
                                          longint'(inv_rms_q[k]), 16)));
    end
    scalars_set = 1'b1;
  endtask

  // Advance the predictor by one accepted transaction; push its result if any
  task automatic predict_grad(in_item_t it);
    longint    x, g, x2, x3, g24, d1, d2, d3, t1, t2, t3, acc;
    out_item_t r;
    x = longint'(it.x_value);
    g = longint'(it.grad_in);
    x2 = x * x;
    x3 = x2 * x;
    g24 = g * 4096;
    if (it.opcode == OPC_ACCUM) begin
      if (scalars_set) clear_row_sums();
      acc_x2  = sat_sum(acc_x2, x2);
      acc_x4  = sat_sum(acc_x4, round_mul(x2, x2, 24));
      acc_x6  = sat_sum(acc_x6, round_mul(x3, x3, 48));
      acc_xg  = sat_sum(acc_xg, x * g);
      acc_x2g = sat_sum(acc_x2g, round_mul(x2, g, 12));
      acc_x3g = sat_sum(acc_x3g, round_mul(x3, g, 24));
      acc_g   = sat_sum(acc_g, g24);
    end else begin
      if (!scalars_set) form_row_scalars();
      d1 = sat_sum(g24, -round_mul(longint'(gamma_q[0]), x, 4));
      d2 = sat_sum(g24, -round_mul(longint'(gamma_q[1]), x2, 16));
      d3 = sat_sum(g24, -round_mul(longint'(gamma_q[2]), x3, 28));
      t1 = round_mul(longint'(alpha_q[0]), d1, 16);
      t2 = round_mul(round_mul(longint'(alpha_q[1]), d2, 16), 2 * x, 12);
      t3 = round_mul(round_mul(longint'(alpha_q[2]), d3, 16), 3 * x2, 24);
      acc = sat_sum(sat_sum(t1, t2), t3);
      r = '0;
      r.grad_x = 32'(clamp32(round_mul(acc, 1, 8)));
      if (it.end_of_row) begin
        r.grad_w_cubic  = 32'(clamp32(round_mul(acc_x3g, longint'(inv_rms_q[2]), 28)));
        r.grad_w_square = 32'(clamp32(round_mul(acc_x2g, longint'(inv_rms_q[1]), 28)));
        r.grad_w_linear = 32'(clamp32(round_mul(acc_xg, longint'(inv_rms_q[0]), 28)));
        r.grad_bias     = 32'(clamp32(round_mul(acc_g, 1, 8)));
        r.last          = 1'b1;
        clear_row_sums();
      end
      expected_grads.push_back(r);
    end
  endtask

  // ------------------------------------------------------- monitors, checker

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) predict_grad(in_data);
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_grads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %h", out_data);
      end else begin
        e = expected_grads.pop_front();
        check_field("grad_x", e.grad_x, out_data.grad_x);
        check_field("grad_w_cubic", e.grad_w_cubic, out_data.grad_w_cubic);
        check_field("grad_w_square", e.grad_w_square, out_data.grad_w_square);
        check_field("grad_w_linear", e.grad_w_linear, out_data.grad_w_linear);
        check_field("grad_bias", e.grad_bias, out_data.grad_bias);
        check_field("last", 32'(e.last), 32'(out_data.last));
      end
    end
  end

  // Drive out_ready: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stop a hung run: count cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("polynomial_rms_norm_backward_top_tb: done, errors");
      $finish;
    end
  end

  // ------------------------------------------------------------ stimulus

  task automatic send_item(logic opc, logic [15:0] x, logic [15:0] g, logic eor);
    in_item_t it;
    it.opcode = opc;
    it.x_value = x;
    it.grad_in = g;
    it.end_of_row = eor;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_grads.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_WEIGHT_CUBIC, CFG_WEIGHT_SQUARE, CFG_WEIGHT_LINEAR: weight_q[idx] = value[15:0];
      CFG_EPSILON:        eps_q = value;
      CFG_INVERSE_LENGTH: inv_len_q = value[16:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_q412();
    case ($urandom_range(2))
      0:       return 16'($urandom_range(65535));
      1:       return 16'($signed($urandom_range(16384)) - 8192);
      default: return 16'($signed($urandom_range(512)) - 256);
    endcase
  endfunction

  // Send one row through both passes; optionally abandon the gradient pass
  task automatic send_row(int len, int grad_len);
    logic [15:0] xs [$];
    logic [15:0] gs [$];
    int          n_grad;
    // a negative gradient length re-sends the whole row
    n_grad = (grad_len < 0) ? len : grad_len;
    for (int i = 0; i < len; i++) begin
      xs.push_back(rand_q412());
      gs.push_back(rand_q412());
      send_item(OPC_ACCUM, xs[i], gs[i], ($urandom_range(9) == 0));
    end
    for (int i = 0; i < n_grad; i++)
      send_item(OPC_GRAD, xs[i], gs[i], (n_grad == len) && (i == len - 1));
  endtask

  task automatic random_config();
    write_reg(CFG_WEIGHT_CUBIC, 32'($signed($urandom_range(16384)) - 8192));
    write_reg(CFG_WEIGHT_SQUARE, 32'($signed($urandom_range(16384)) - 8192));
    write_reg(CFG_WEIGHT_LINEAR, $urandom_range(3) == 0 ? $urandom : 32'(4096));
    write_reg(CFG_EPSILON, $urandom_range(3) == 0 ? $urandom : $urandom_range(65535));
    write_reg(CFG_INVERSE_LENGTH, $urandom_range(3) == 0 ? $urandom_range(131071)
                                                         : 32'(65536 >> $urandom_range(3)));
  endtask

  // Extremes of the fields, accumulate end_of_row, gradient pass with no accumulate
  task automatic test_field_extremes();
    send_item(OPC_GRAD, 16'h1000, 16'h1000, 1'b1);
    send_item(OPC_ACCUM, 16'h8000, 16'h7fff, 1'b1);
    send_item(OPC_ACCUM, 16'h7fff, 16'h8000, 1'b0);
    send_item(OPC_ACCUM, 16'h0000, 16'hffff, 1'b0);
    send_item(OPC_GRAD, 16'h8000, 16'h7fff, 1'b0);
    send_item(OPC_GRAD, 16'h7fff, 16'h8000, 1'b0);
    send_item(OPC_GRAD, 16'h0000, 16'hffff, 1'b1);
    go_idle();
  endtask

  // Accumulate arriving mid gradient pass starts a new row
  task automatic test_abandoned_pass();
    send_row(3, 1);
    send_row(2, 2);
    go_idle();
  endtask

  // Zero variance: all-zero row with zero epsilon
  task automatic test_zero_variance();
    write_reg(CFG_EPSILON, 32'd0);
    send_item(OPC_ACCUM, 16'h0000, 16'h0400, 1'b0);
    send_item(OPC_ACCUM, 16'h0000, 16'hfc00, 1'b1);
    send_item(OPC_GRAD, 16'h0000, 16'h0400, 1'b0);
    send_item(OPC_GRAD, 16'h0000, 16'hfc00, 1'b1);
    send_item(OPC_GRAD, 16'h0010, 16'h0010, 1'b1);
    go_idle();
  endtask

  // Register extremes, including inverse length above one
  task automatic test_register_extremes();
    write_reg(CFG_WEIGHT_CUBIC, 32'hffff_8000);
    write_reg(CFG_WEIGHT_SQUARE, 32'h0000_7fff);
    write_reg(CFG_WEIGHT_LINEAR, 32'hffff_8000);
    write_reg(CFG_EPSILON, 32'hffff_ffff);
    write_reg(CFG_INVERSE_LENGTH, 32'd131071);
    send_row(2, 2);
    go_idle();
    write_reg(CFG_WEIGHT_CUBIC, 32'h0000_7fff);
    write_reg(CFG_WEIGHT_LINEAR, 32'h0000_7fff);
    write_reg(CFG_EPSILON, 32'd0);
    write_reg(CFG_INVERSE_LENGTH, 32'd0);
    send_row(2, 2);
    go_idle();
  endtask

  task automatic test_random_rows(int count);
    int target;
    int pick;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 80) send_row($urandom_range(5) == 0 ? $urandom_range(16, 1)
                                                    : $urandom_range(6, 1), -1);
      else if (pick < 88) send_row($urandom_range(6, 2), $urandom_range(1, 1));
      else send_item(1'($urandom), rand_q412(), rand_q412(), 1'($urandom));
    end
    go_idle();
  endtask

  // Hold the receiver off while rows keep coming, then drain
  task automatic test_backpressure();
    hold_request = 400;
    send_row(4, 4);
    send_row(3, 3);
    go_idle();
  endtask

  // Long row of accumulate transactions before a short gradient pass
  task automatic test_overlong_row();
    for (int i = 0; i < LONG_ROW; i++)
      send_item(OPC_ACCUM, rand_q412(), rand_q412(), i == LONG_ROW - 1);
    send_item(OPC_GRAD, 16'h7fff, 16'h7fff, 1'b0);
    send_item(OPC_GRAD, 16'h8000, 16'h8000, 1'b1);
    go_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_WEIGHT_CUBIC;
    cfg_data = '0;
    weight_q = '{16'sd4096, 16'sd4096, 16'sd4096};
    eps_q = 32'd4295;
    inv_len_q = 17'd65536;
    inv_rms_q = '{32'd0, 32'd0, 32'd0};
    gamma_q = '{0, 0, 0};
    alpha_q = '{0, 0, 0};
    clear_row_sums();
    mismatches = 0;
    items_sent = 0;
    hold_request = 0;
    hold_left = 0;
    quiet_cycles = 0;
    send_idle_pct = 23;
    recv_idle_pct = 76;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_abandoned_pass();
    test_zero_variance();
    test_register_extremes();
    random_config();
    test_random_rows(100);
    send_idle_pct = 76;
    recv_idle_pct = 23;
    random_config();
    test_random_rows(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_config();
    test_random_rows(100);
    test_backpressure();
    test_overlong_row();

    if (mismatches == 0 && expected_grads.size() == 0)
      $display("polynomial_rms_norm_backward_top_tb: done, clean");
    else
      $display("polynomial_rms_norm_backward_top_tb: done, errors");
    $finish;
  end

endmodule
